[hw/rtl/fat_chain_allocator_defines.svh]
// Assertion macros for the allocation table block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef FAT_CHAIN_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fca_pkg.sv]
// Shared types and codes for the allocation table block.
// No dependencies.
package fca_pkg;

    localparam int BLOCK_W  = 10;
    localparam int STATUS_W = 2;
    localparam int OPCODE_W = 3;
    localparam int INDEX_LIMIT = 1024;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FORMAT = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_LINK   = 3'd2,
        OP_FREE   = 3'd3,
        OP_NEXT   = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_END  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_ALLOC,
        S_LINK,
        S_FREE,
        S_NEXT
    } state_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_index;
        status_t            status;
    } result_t;

endpackage

[hw/rtl/fca_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fca_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fca_seq.sv]
// Operation sequencer: format sweep, allocate scan, link, chain free, lookup.
// Depends on fca_pkg; drives the link table RAM.
module fca_seq #(
    parameter int BLOCK_COUNT           = 1024,
    parameter int LINKS_PER_TABLE_BLOCK = 512
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [fca_pkg::OPCODE_W-1:0]          opcode,
    input  logic [fca_pkg::BLOCK_W-1:0]           block_a,
    input  logic [fca_pkg::BLOCK_W-1:0]           block_b,
    output logic                                  busy,
    output logic                                  ram_we,
    output logic [$clog2(BLOCK_COUNT)-1:0]        ram_waddr,
    output logic [$clog2(BLOCK_COUNT+2)-1:0]      ram_wdata,
    output logic [$clog2(BLOCK_COUNT)-1:0]        ram_raddr,
    input  logic [$clog2(BLOCK_COUNT+2)-1:0]      ram_rdata,
    output logic                                  res_valid,
    output fca_pkg::result_t                      res
);

    localparam int AW = $clog2(BLOCK_COUNT);
    localparam int EW = $clog2(BLOCK_COUNT + 2);
    localparam int HW = $clog2(BLOCK_COUNT + 1);
    localparam int TABLE_BLOCKS =
        (BLOCK_COUNT + LINKS_PER_TABLE_BLOCK - 1) / LINKS_PER_TABLE_BLOCK;
    localparam int LIMIT = (BLOCK_COUNT < fca_pkg::INDEX_LIMIT) ?
        BLOCK_COUNT : fca_pkg::INDEX_LIMIT;
    localparam int FMT_HINT = (TABLE_BLOCKS + 2 < BLOCK_COUNT) ?
        TABLE_BLOCKS + 2 : BLOCK_COUNT;

    localparam logic [EW-1:0] UNUSED_V = EW'(BLOCK_COUNT);
    localparam logic [EW-1:0] EOC_V    = EW'(BLOCK_COUNT + 1);
    localparam logic [HW-1:0] LAST_IDX = HW'(BLOCK_COUNT - 1);
    localparam logic [HW-1:0] TBL_END  = HW'(TABLE_BLOCKS);
    localparam logic [HW-1:0] ROOT_IDX = HW'(TABLE_BLOCKS + 1);

    fca_pkg::state_t state_reg, state_next;
    logic [HW-1:0]   ptr_reg, ptr_next;
    logic [HW-1:0]   hint_reg, hint_next;
    logic            chk_v_reg, chk_v_next;
    logic [AW-1:0]   chk_addr_reg, chk_addr_next;

    logic            a_ok;
    logic            b_ok;
    logic [EW-1:0]   fmt_value;

    assign a_ok = (32'(block_a) < BLOCK_COUNT);
    assign b_ok = (32'(block_b) < BLOCK_COUNT);
    assign busy = (state_reg != fca_pkg::S_IDLE);

    // format image of entry ptr_reg
    always_comb
    begin
        priority if (ptr_reg == '0)
            fmt_value = EOC_V;
        else if (ptr_reg < TBL_END)
            fmt_value = EW'(ptr_reg) + EW'(1);
        else if (ptr_reg == TBL_END || ptr_reg == ROOT_IDX)
            fmt_value = EOC_V;
        else
            fmt_value = UNUSED_V;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fca_pkg::S_IDLE;
            ptr_reg      <= '0;
            hint_reg     <= '0;
            chk_v_reg    <= 1'b0;
            chk_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            hint_reg     <= hint_next;
            chk_v_reg    <= chk_v_next;
            chk_addr_reg <= chk_addr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        hint_next     = hint_reg;
        chk_v_next    = chk_v_reg;
        chk_addr_next = chk_addr_reg;
        ram_we        = 1'b0;
        ram_waddr     = chk_addr_reg;
        ram_wdata     = UNUSED_V;
        ram_raddr     = AW'(block_a);
        res_valid     = 1'b0;
        res.block_index = '0;
        res.status      = fca_pkg::ST_OK;

        unique case (state_reg)
            fca_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (fca_pkg::opcode_t'(opcode))
                        fca_pkg::OP_FORMAT:
                        begin
                            ptr_next   = '0;
                            state_next = fca_pkg::S_FMT;
                        end
                        fca_pkg::OP_ALLOC:
                        begin
                            ptr_next   = hint_reg;
                            chk_v_next = 1'b0;
                            state_next = fca_pkg::S_ALLOC;
                        end
                        fca_pkg::OP_LINK:
                        begin
                            if (a_ok && b_ok)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = AW'(block_a);
                                ram_wdata     = EW'(block_b);
                                chk_addr_next = AW'(block_b);
                                state_next    = fca_pkg::S_LINK;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        fca_pkg::OP_FREE:
                        begin
                            if (a_ok)
                            begin
                                chk_addr_next = AW'(block_a);
                                state_next    = fca_pkg::S_FREE;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        fca_pkg::OP_NEXT:
                        begin
                            if (a_ok)
                            begin
                                state_next = fca_pkg::S_NEXT;
                            end
                            else
                            begin
                                res_valid  = 1'b1;
                                res.status = fca_pkg::ST_END;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end

            fca_pkg::S_FMT:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(ptr_reg);
                ram_wdata = fmt_value;
                if (ptr_reg == LAST_IDX)
                begin
                    res_valid  = 1'b1;
                    hint_next  = HW'(FMT_HINT);
                    state_next = fca_pkg::S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + HW'(1);
                end
            end

            // reads issued back to back; each read is checked in the following cycle
            fca_pkg::S_ALLOC:
            begin
                if (chk_v_reg && ram_rdata == UNUSED_V)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = chk_addr_reg;
                    ram_wdata       = EOC_V;
                    res_valid       = 1'b1;
                    res.block_index = fca_pkg::BLOCK_W'(chk_addr_reg);
                    hint_next       = HW'(chk_addr_reg) + HW'(1);
                    state_next      = fca_pkg::S_IDLE;
                end
                else if (ptr_reg < HW'(LIMIT))
                begin
                    ram_raddr     = AW'(ptr_reg);
                    chk_v_next    = 1'b1;
                    chk_addr_next = AW'(ptr_reg);
                    ptr_next      = ptr_reg + HW'(1);
                end
                else
                begin
                    res_valid  = 1'b1;
                    res.status = fca_pkg::ST_FULL;
                    state_next = fca_pkg::S_IDLE;
                end
            end

            fca_pkg::S_LINK:
            begin
                ram_we     = 1'b1;
                ram_waddr  = chk_addr_reg;
                ram_wdata  = EOC_V;
                res_valid  = 1'b1;
                state_next = fca_pkg::S_IDLE;
            end

            // a chain never points at itself, so the write and the next read differ
            fca_pkg::S_FREE:
            begin
                if (ram_rdata == UNUSED_V)
                begin
                    res_valid  = 1'b1;
                    state_next = fca_pkg::S_IDLE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_addr_reg;
                    ram_wdata = UNUSED_V;
                    if (HW'(chk_addr_reg) < hint_reg)
                    begin
                        hint_next = HW'(chk_addr_reg);
                    end
                    if (ram_rdata < UNUSED_V)
                    begin
                        ram_raddr     = AW'(ram_rdata);
                        chk_addr_next = AW'(ram_rdata);
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        state_next = fca_pkg::S_IDLE;
                    end
                end
            end

            fca_pkg::S_NEXT:
            begin
                res_valid  = 1'b1;
                state_next = fca_pkg::S_IDLE;
                if (ram_rdata < UNUSED_V)
                begin
                    res.block_index = fca_pkg::BLOCK_W'(ram_rdata);
                end
                else
                begin
                    res.status = fca_pkg::ST_END;
                end
            end

            default:
            begin
                state_next = fca_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/fat_chain_allocator.sv]
// Operations: format writes every entry; allocate scans from the lowest possibly unused
// block; link writes both entries; free chain reads each entry and releases each block
// until the chain end or an unused entry stops the walk; next reads one entry;
// out-of-range or unknown operations end without a table access. One operation at a time:
// the next word is accepted in the cycle done is high, and not while an operation runs.
// rst_n clears control and the output strobe; the link table is undefined until format.
// Results cannot be stalled: done marks a single-cycle word.
module fat_chain_allocator #(
    parameter int BLOCK_COUNT           = 1024,
    parameter int LINKS_PER_TABLE_BLOCK = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fca_pkg::OPCODE_W-1:0]  opcode,
    input  logic [fca_pkg::BLOCK_W-1:0]   block_a,
    input  logic [fca_pkg::BLOCK_W-1:0]   block_b,
    output logic                          done,
    output logic [fca_pkg::BLOCK_W-1:0]   block_index,
    output logic [fca_pkg::STATUS_W-1:0]  status
);

    localparam int AW = $clog2(BLOCK_COUNT);
    localparam int EW = $clog2(BLOCK_COUNT + 2);

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;
    logic             res_valid;
    fca_pkg::result_t res;

    logic             done_reg;
    fca_pkg::result_t res_reg;

    fca_ram #(
        .WIDTH (EW),
        .DEPTH (BLOCK_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fca_seq #(
        .BLOCK_COUNT           (BLOCK_COUNT),
        .LINKS_PER_TABLE_BLOCK (LINKS_PER_TABLE_BLOCK)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .block_a   (block_a),
        .block_b   (block_b),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign done        = done_reg;
    assign block_index = res_reg.block_index;
    assign status      = res_reg.status;

endmodule

[hw/rtl/fca_check.sv]
// Port-level checker for fat_chain_allocator, bound to the top level.
// Depends on fca_pkg and fat_chain_allocator_defines.svh.
`include "fat_chain_allocator_defines.svh"

module fca_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [fca_pkg::OPCODE_W-1:0]  opcode,
    input logic                          done,
    input logic [fca_pkg::BLOCK_W-1:0]   block_index,
    input logic [fca_pkg::STATUS_W-1:0]  status
);

    `FCA_ASSERT_NEXT(a_accept_resp, start && !busy, busy || done, "accepted word left no trace")
    `FCA_ASSERT_SAME(a_busy_end_done, $fell(busy), done, "operation ended without a result")
    `FCA_ASSERT_SAME(a_status_code, done, status == fca_pkg::ST_OK || status == fca_pkg::ST_FULL || status == fca_pkg::ST_END, "illegal status code")
    `FCA_ASSERT_SAME(a_fail_index, done && status != fca_pkg::ST_OK, block_index == '0, "nonzero index on failure")
    `FCA_ASSERT_SAME(a_full_only_alloc, done && status == fca_pkg::ST_FULL && $past(start && !busy), $past(opcode) == fca_pkg::OP_ALLOC, "full reported for a non-allocate word")

endmodule

bind fat_chain_allocator fca_check u_fca_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .done        (done),
    .block_index (block_index),
    .status      (status)
);
